// File: rtl/pbfl_pkg.sv
// pbfl_pkg: shared types and constants of the page block free list
// holds item structs, request/status codes, sequencer states and link ram port struct
// no dependencies
package pbfl_pkg;

  // page geometry
  localparam int unsigned MAX_BLOCKS  = 256;
  localparam int unsigned MAX_REQUEST = 64;
  localparam int unsigned PTR_W       = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W       = $clog2(MAX_REQUEST + 1);
  localparam logic [PTR_W-1:0] EMPTY_PTR = PTR_W'(MAX_BLOCKS);

  // request codes
  typedef enum logic [2:0] {
    REQ_MARK_UNUSED    = 3'd0,
    REQ_INIT           = 3'd1,
    REQ_ALLOC          = 3'd2,
    REQ_CHECKED_FREE   = 3'd3,
    REQ_UNCHECKED_FREE = 3'd4
  } req_type_e;

  // free status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_WAS_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_LINK,
    S_OUT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  block_index;
    logic [6:0]  request_count;
    logic [7:0]  size_class;
    logic [7:0]  node_id;
    logic [8:0]  block_count;
    logic [15:0] next_link;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  allocated_block;
    logic        has_block;
    logic        last;
    logic [1:0]  status;
    logic [6:0]  allocated_count;
    logic [15:0] next_link_out;
    logic        now_empty;
  } out_item_t;

  // link ram access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [PTR_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/pbfl_link_ram.sv
// pbfl_link_ram: next-block link storage, one write and one registered read port
// depends on pbfl_pkg
module pbfl_link_ram (
  input  logic                         clk_i,
  input  pbfl_pkg::ram_req_t           req_i,
  output logic [pbfl_pkg::PTR_W-1:0]   rdata_o
);

  logic [pbfl_pkg::PTR_W-1:0] mem [pbfl_pkg::MAX_BLOCKS];
  logic [pbfl_pkg::PTR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pbfl_core.sv
// pbfl_core: request sequencer with one shared adder over the link ram
// depends on pbfl_pkg; drives pbfl_link_ram through a ram_req_t struct
module pbfl_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pbfl_pkg::in_item_t           in_item_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output pbfl_pkg::out_item_t          res_item_o,
  output pbfl_pkg::ram_req_t           ram_req_o,
  input  logic [pbfl_pkg::PTR_W-1:0]   ram_rdata_i
);

  pbfl_pkg::state_e state_q, state_d;

  // list state
  logic [pbfl_pkg::PTR_W-1:0] head_q, head_d;
  logic [pbfl_pkg::PTR_W-1:0] outst_q, outst_d;
  logic [7:0]                 class_q, class_d;
  logic [7:0]                 node_q, node_d;
  logic                       cvalid_q, cvalid_d;
  logic [15:0]                dlink_q, dlink_d;

  // per-request working registers
  logic [pbfl_pkg::PTR_W-1:0] cur_q, cur_d;
  logic [pbfl_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [pbfl_pkg::CNT_W-1:0] reqmax_q, reqmax_d;
  logic [pbfl_pkg::PTR_W-1:0] initn_q, initn_d;
  logic [pbfl_pkg::PTR_W-1:0] idx_q, idx_d;
  pbfl_pkg::out_item_t        res_q, res_d;

  // shared adder
  logic [pbfl_pkg::PTR_W-1:0] alu_a, alu_b;
  logic [pbfl_pkg::PTR_W:0]   alu_sum;

  logic                       accept;
  pbfl_pkg::req_type_e        req;
  logic                       match;
  logic                       head_empty;
  logic                       nxt_empty;
  logic                       link_last;
  logic [pbfl_pkg::PTR_W-1:0] init_n;
  logic [pbfl_pkg::CNT_W-1:0] req_clip;
  pbfl_pkg::status_e          free_st;

  assign accept     = in_valid_i && in_ready_o;
  assign req        = pbfl_pkg::req_type_e'(in_item_i.req_type);
  assign match      = cvalid_q && (class_q == in_item_i.size_class)
                      && (node_q == in_item_i.node_id);
  assign head_empty = head_q >= pbfl_pkg::EMPTY_PTR;
  assign nxt_empty  = ram_rdata_i >= pbfl_pkg::EMPTY_PTR;
  assign link_last  = (alu_sum[pbfl_pkg::CNT_W-1:0] == reqmax_q) || nxt_empty;

  // clamp init count and alloc request
  always_comb begin
    if (in_item_i.block_count == '0) begin
      init_n = pbfl_pkg::PTR_W'(1);
    end else if (in_item_i.block_count > pbfl_pkg::EMPTY_PTR) begin
      init_n = pbfl_pkg::EMPTY_PTR;
    end else begin
      init_n = in_item_i.block_count;
    end
    if (in_item_i.request_count > pbfl_pkg::CNT_W'(pbfl_pkg::MAX_REQUEST)) begin
      req_clip = pbfl_pkg::CNT_W'(pbfl_pkg::MAX_REQUEST);
    end else begin
      req_clip = in_item_i.request_count;
    end
  end

  // free status, shared by both free flavors
  always_comb begin
    if (outst_q == pbfl_pkg::PTR_W'(1)) begin
      free_st = pbfl_pkg::ST_FULL;
    end else if (head_empty) begin
      free_st = pbfl_pkg::ST_WAS_EMPTY;
    end else begin
      free_st = pbfl_pkg::ST_OK;
    end
  end

  // adder operand select: index step, grant step, outstanding update
  always_comb begin
    case (state_q)
      pbfl_pkg::S_INIT: begin
        alu_a = idx_q;
        alu_b = pbfl_pkg::PTR_W'(1);
      end
      pbfl_pkg::S_LINK: begin
        alu_a = pbfl_pkg::PTR_W'(cnt_q);
        alu_b = pbfl_pkg::PTR_W'(1);
      end
      pbfl_pkg::S_FIN: begin
        alu_a = outst_q;
        alu_b = pbfl_pkg::PTR_W'(cnt_q);
      end
      default: begin
        // decrement by adding all ones
        alu_a = outst_q;
        alu_b = '1;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbfl_pkg::S_IDLE: begin
        if (accept) begin
          case (req)
            pbfl_pkg::REQ_INIT: begin
              if (!match) state_d = pbfl_pkg::S_INIT;
            end
            pbfl_pkg::REQ_ALLOC: begin
              if (req_clip == '0 || head_empty) state_d = pbfl_pkg::S_OUT;
              else                              state_d = pbfl_pkg::S_RD;
            end
            pbfl_pkg::REQ_CHECKED_FREE:   state_d = pbfl_pkg::S_OUT;
            pbfl_pkg::REQ_UNCHECKED_FREE: state_d = pbfl_pkg::S_OUT;
            default:                      state_d = pbfl_pkg::S_IDLE;
          endcase
        end
      end
      pbfl_pkg::S_INIT: begin
        if (alu_sum == {1'b0, initn_q}) state_d = pbfl_pkg::S_IDLE;
      end
      pbfl_pkg::S_RD:   state_d = pbfl_pkg::S_LINK;
      pbfl_pkg::S_LINK: state_d = pbfl_pkg::S_OUT;
      pbfl_pkg::S_OUT: begin
        if (res_ready_i) begin
          if (!res_q.last)          state_d = pbfl_pkg::S_RD;
          else if (res_q.has_block) state_d = pbfl_pkg::S_FIN;
          else                      state_d = pbfl_pkg::S_IDLE;
        end
      end
      pbfl_pkg::S_FIN: state_d = pbfl_pkg::S_IDLE;
      default:         state_d = pbfl_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_d    = head_q;
    outst_d   = outst_q;
    class_d   = class_q;
    node_d    = node_q;
    cvalid_d  = cvalid_q;
    dlink_d   = dlink_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    reqmax_d  = reqmax_q;
    initn_d   = initn_q;
    idx_d     = idx_q;
    res_d     = res_q;
    ram_req_o = '0;
    case (state_q)
      pbfl_pkg::S_IDLE: begin
        if (accept) begin
          case (req)
            pbfl_pkg::REQ_MARK_UNUSED: begin
              dlink_d  = in_item_i.next_link;
              class_d  = '0;
              node_d   = '0;
              cvalid_d = 1'b0;
              outst_d  = '0;
              head_d   = pbfl_pkg::EMPTY_PTR;
            end
            pbfl_pkg::REQ_INIT: begin
              if (!match) begin
                class_d  = in_item_i.size_class;
                node_d   = in_item_i.node_id;
                cvalid_d = 1'b1;
                outst_d  = '0;
                dlink_d  = '0;
                head_d   = '0;
                idx_d    = '0;
                initn_d  = init_n;
              end
            end
            pbfl_pkg::REQ_ALLOC: begin
              cur_d    = head_q;
              cnt_d    = '0;
              reqmax_d = req_clip;
              // nothing to grant: single summary result
              res_d                 = '0;
              res_d.last            = 1'b1;
              res_d.next_link_out   = dlink_q;
              res_d.now_empty       = head_empty;
            end
            pbfl_pkg::REQ_CHECKED_FREE: begin
              if (free_st == pbfl_pkg::ST_OK) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = in_item_i.block_index;
                ram_req_o.wdata = head_q;
                head_d          = pbfl_pkg::PTR_W'(in_item_i.block_index);
                if (outst_q != '0) outst_d = alu_sum[pbfl_pkg::PTR_W-1:0];
              end
              res_d        = '0;
              res_d.last   = 1'b1;
              res_d.status = free_st;
            end
            pbfl_pkg::REQ_UNCHECKED_FREE: begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = in_item_i.block_index;
              ram_req_o.wdata = head_q;
              head_d          = pbfl_pkg::PTR_W'(in_item_i.block_index);
              if (outst_q != '0) outst_d = alu_sum[pbfl_pkg::PTR_W-1:0];
              res_d        = '0;
              res_d.last   = 1'b1;
              res_d.status = free_st;
            end
            default: begin
              res_d = res_q;
            end
          endcase
        end
      end
      // thread blocks in address order, one link per cycle
      pbfl_pkg::S_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[pbfl_pkg::IDX_W-1:0];
        if (alu_sum == {1'b0, initn_q}) ram_req_o.wdata = pbfl_pkg::EMPTY_PTR;
        else                            ram_req_o.wdata = alu_sum[pbfl_pkg::PTR_W-1:0];
        idx_d = alu_sum[pbfl_pkg::PTR_W-1:0];
      end
      pbfl_pkg::S_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = cur_q[pbfl_pkg::IDX_W-1:0];
      end
      // link of the current block is back: hand it out
      pbfl_pkg::S_LINK: begin
        cnt_d                 = alu_sum[pbfl_pkg::CNT_W-1:0];
        cur_d                 = ram_rdata_i;
        res_d                 = '0;
        res_d.allocated_block = cur_q[pbfl_pkg::IDX_W-1:0];
        res_d.has_block       = 1'b1;
        res_d.last            = link_last;
        if (link_last) begin
          head_d                = ram_rdata_i;
          res_d.allocated_count = alu_sum[pbfl_pkg::CNT_W-1:0];
          res_d.next_link_out   = dlink_q;
          res_d.now_empty       = nxt_empty;
        end
      end
      // saturating outstanding update after a grant
      pbfl_pkg::S_FIN: begin
        if (alu_sum > {1'b0, pbfl_pkg::EMPTY_PTR}) outst_d = pbfl_pkg::EMPTY_PTR;
        else                                       outst_d = alu_sum[pbfl_pkg::PTR_W-1:0];
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // control and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pbfl_pkg::S_IDLE;
      head_q   <= pbfl_pkg::EMPTY_PTR;
      outst_q  <= '0;
      class_q  <= '0;
      node_q   <= '0;
      cvalid_q <= 1'b0;
      dlink_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      outst_q  <= outst_d;
      class_q  <= class_d;
      node_q   <= node_d;
      cvalid_q <= cvalid_d;
      dlink_q  <= dlink_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    reqmax_q <= reqmax_d;
    initn_q  <= initn_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
  end

  assign in_ready_o  = state_q == pbfl_pkg::S_IDLE;
  assign res_valid_o = state_q == pbfl_pkg::S_OUT;
  assign res_item_o  = res_q;

  // head is a block index or the empty marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= pbfl_pkg::EMPTY_PTR)
    else $error("list head out of range");

  // outstanding count saturates at the page size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= pbfl_pkg::EMPTY_PTR)
    else $error("outstanding count above page size");

  // a result without a block always closes its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_item_o.has_block |-> res_item_o.last)
    else $error("blockless result not marked last");

  // the walk never grants more than asked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbfl_pkg::S_RD || state_q == pbfl_pkg::S_LINK) |-> cnt_q < reqmax_q)
    else $error("grant count reached request during walk");

  // a fetched link is always followed by a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pbfl_pkg::S_LINK |=> state_q == pbfl_pkg::S_OUT)
    else $error("link fetch not followed by result");

endmodule

// File: rtl/page_block_free_list_top.sv
// page_block_free_list_top: slab page free list with output register stage
// depends on pbfl_pkg, pbfl_core, pbfl_link_ram
//
//  channel | signals                           | direction | transfer when
//  --------+-----------------------------------+-----------+------------------------
//  request | in_valid_i, in_ready_o, in_item_i | in        | in_valid_i && in_ready_o
//  result  | out_valid_o, out_ready_i, out_item_o | out    | out_valid_o && out_ready_i
//
// mark unused and a matching init stay in the idle state; any other init threads the clamped
// block count into the link ram, one link write per cycle.
// alloc walks the list: each granted block costs a link ram read, the returned link and the
// result handoff, then one outstanding update; an empty grant sends only a summary result.
// frees go straight to their result. results leave through a one-entry output register.
// reset empties the list; link ram contents stay undefined until an init or free writes them.
// a stalled result holds the sequencer only once the output register is also full.
module page_block_free_list_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pbfl_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pbfl_pkg::out_item_t  out_item_o
);

  logic                       res_valid;
  logic                       res_ready;
  pbfl_pkg::out_item_t        res_item;
  pbfl_pkg::ram_req_t         ram_req;
  logic [pbfl_pkg::PTR_W-1:0] ram_rdata;

  logic                       obuf_valid_q;
  pbfl_pkg::out_item_t        obuf_q;

  pbfl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  pbfl_link_ram u_link_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register takes a result when empty or draining
  assign res_ready = !obuf_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      obuf_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      obuf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      obuf_q <= res_item;
    end
  end

  assign out_valid_o = obuf_valid_q;
  assign out_item_o  = obuf_q;

endmodule

// File: sim/page_block_free_list_top_tb.sv
`timescale 1ns / 100ps
// page_block_free_list_top_tb: self-checking bench for the page block free list
// keeps its own copy of the page list, predicts each result and checks every transfer
// depends on pbfl_pkg and page_block_free_list_top

module page_block_free_list_top_tb;

  localparam int unsigned REQ_ITEMS  = 330;
  localparam int unsigned MAX_WAIT   = 11;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned DRAIN_WAIT = 400;   // covers a full-page init
  localparam int unsigned HOLD_FIRST = 40;
  localparam int unsigned HOLD_NEXT  = 200;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  pbfl_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pbfl_pkg::out_item_t out_item;

  // page list copy
  logic [pbfl_pkg::PTR_W-1:0] page_next [pbfl_pkg::MAX_BLOCKS];
  logic [pbfl_pkg::PTR_W-1:0] page_head     = pbfl_pkg::EMPTY_PTR;
  int unsigned                blocks_out    = 0;
  logic [7:0]                 page_class    = '0;
  logic [7:0]                 page_node     = '0;
  logic                       page_class_ok = 1'b0;
  logic [15:0]                page_desc     = '0;

  pbfl_pkg::out_item_t due_results [$];
  pbfl_pkg::in_item_t  req_backlog [$];
  int unsigned err_count     = 0;
  int unsigned queued_total  = 0;
  int unsigned req_total     = 0;
  int unsigned accepted_reqs = 0;
  int unsigned seen_results  = 0;
  int unsigned src_wait      = 0;
  int unsigned sink_wait     = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_idx      = 0;

  page_block_free_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic pbfl_pkg::in_item_t noise_item();
    pbfl_pkg::in_item_t it;
    it.req_type      = 3'($urandom_range(0, 7));
    it.block_index   = 8'($urandom);
    it.request_count = 7'($urandom);
    it.size_class    = 8'($urandom);
    it.node_id       = 8'($urandom);
    it.block_count   = 9'($urandom);
    it.next_link     = 16'($urandom);
    return it;
  endfunction

  task automatic push_item(input pbfl_pkg::in_item_t it);
    req_backlog.push_back(it);
    queued_total++;
    if (it.req_type <= pbfl_pkg::REQ_UNCHECKED_FREE) req_total++;
  endtask

  // arg is the field that the request uses, the rest stays random
  task automatic push_req(input logic [2:0] kind, input int unsigned arg,
                          input logic [7:0] cls, input logic [7:0] node);
    pbfl_pkg::in_item_t it;
    it = noise_item();
    it.req_type = kind;
    case (kind)
      pbfl_pkg::REQ_MARK_UNUSED: it.next_link = 16'(arg);
      pbfl_pkg::REQ_INIT: begin
        it.block_count = 9'(arg);
        it.size_class  = cls;
        it.node_id     = node;
      end
      pbfl_pkg::REQ_ALLOC: it.request_count = 7'(arg);
      default: it.block_index = 8'(arg);
    endcase
    push_item(it);
  endtask

  // apply one accepted request to the page copy and queue its results
  task automatic page_apply(input pbfl_pkg::in_item_t req);
    pbfl_pkg::out_item_t        res;
    logic [pbfl_pkg::PTR_W-1:0] cur;
    int unsigned                want, granted, span, k;
    logic                       was_empty, one_out;
    res = '0;
    case (req.req_type)
      pbfl_pkg::REQ_MARK_UNUSED: begin
        page_desc     = req.next_link;
        page_class    = '0;
        page_node     = '0;
        page_class_ok = 1'b0;
        blocks_out    = 0;
        page_head     = pbfl_pkg::EMPTY_PTR;
      end
      pbfl_pkg::REQ_INIT: begin
        // same class and node on a live page leaves it alone
        if (!(page_class_ok && page_class == req.size_class && page_node == req.node_id)) begin
          span = req.block_count;
          if (span == 0) span = 1;
          if (span > pbfl_pkg::MAX_BLOCKS) span = pbfl_pkg::MAX_BLOCKS;
          for (k = 0; k < span; k++)
            page_next[k] = (k + 1 == span) ? pbfl_pkg::EMPTY_PTR : pbfl_pkg::PTR_W'(k + 1);
          page_head     = '0;
          page_class    = req.size_class;
          page_node     = req.node_id;
          page_class_ok = 1'b1;
          blocks_out    = 0;
          page_desc     = '0;
        end
      end
      pbfl_pkg::REQ_ALLOC: begin
        want    = (req.request_count > pbfl_pkg::MAX_REQUEST) ? pbfl_pkg::MAX_REQUEST
                                                              : req.request_count;
        cur     = page_head;
        granted = 0;
        // pop in list order, summary rides on the final grant
        while (granted < want && cur < pbfl_pkg::MAX_BLOCKS) begin
          res                 = '0;
          res.allocated_block = cur[pbfl_pkg::IDX_W-1:0];
          res.has_block       = 1'b1;
          granted++;
          cur = page_next[cur[pbfl_pkg::IDX_W-1:0]];
          if (granted == want || cur >= pbfl_pkg::MAX_BLOCKS) begin
            res.last            = 1'b1;
            res.allocated_count = 7'(granted);
            res.next_link_out   = page_desc;
            res.now_empty       = (cur >= pbfl_pkg::MAX_BLOCKS);
          end
          due_results.push_back(res);
        end
        page_head  = cur;
        blocks_out = blocks_out + granted;
        if (blocks_out > pbfl_pkg::MAX_BLOCKS) blocks_out = pbfl_pkg::MAX_BLOCKS;
        if (granted == 0) begin
          res               = '0;
          res.last          = 1'b1;
          res.next_link_out = page_desc;
          res.now_empty     = (cur >= pbfl_pkg::MAX_BLOCKS);
          due_results.push_back(res);
        end
      end
      pbfl_pkg::REQ_CHECKED_FREE: begin
        res.last = 1'b1;
        if (blocks_out == 1) begin
          res.status = pbfl_pkg::ST_FULL;
        end else if (page_head >= pbfl_pkg::MAX_BLOCKS) begin
          res.status = pbfl_pkg::ST_WAS_EMPTY;
        end else begin
          page_next[req.block_index] = page_head;
          page_head = pbfl_pkg::PTR_W'(req.block_index);
          if (blocks_out > 0) blocks_out--;
          res.status = pbfl_pkg::ST_OK;
        end
        due_results.push_back(res);
      end
      pbfl_pkg::REQ_UNCHECKED_FREE: begin
        was_empty = (page_head >= pbfl_pkg::MAX_BLOCKS);
        one_out   = (blocks_out == 1);
        page_next[req.block_index] = page_head;
        page_head = pbfl_pkg::PTR_W'(req.block_index);
        if (blocks_out > 0) blocks_out--;
        res.last   = 1'b1;
        res.status = one_out ? pbfl_pkg::ST_FULL
                             : (was_empty ? pbfl_pkg::ST_WAS_EMPTY : pbfl_pkg::ST_OK);
        due_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, seen_results, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result(input pbfl_pkg::out_item_t got);
    pbfl_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer %p", got));
    end else begin
      want = due_results.pop_front();
      compare_field("allocated_block", 16'(got.allocated_block), 16'(want.allocated_block));
      compare_field("has_block", 16'(got.has_block), 16'(want.has_block));
      compare_field("last", 16'(got.last), 16'(want.last));
      compare_field("status", 16'(got.status), 16'(want.status));
      compare_field("allocated_count", 16'(got.allocated_count), 16'(want.allocated_count));
      compare_field("next_link_out", got.next_link_out, want.next_link_out);
      compare_field("now_empty", 16'(got.now_empty), 16'(want.now_empty));
    end
    seen_results++;
  endtask

  // request driver: one item per transfer, random gap after each
  always @(posedge clk_i) begin : drive
    logic offer;
    if (rst_ni) begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        page_apply(in_item);
        accepted_reqs++;
        offer    = 1'b0;
        src_wait = draw_wait((accepted_reqs / 40) % 3 == 1);
      end
      if (!offer && src_wait > 0) begin
        src_wait--;
      end else if (!offer && req_backlog.size() != 0) begin
        in_item <= req_backlog.pop_front();
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // long receiver hold-offs to back up the block
  always @(posedge clk_i) begin : hold_ctl
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_idx < 2 &&
                   accepted_reqs >= ((hold_idx == 0) ? HOLD_FIRST : HOLD_NEXT)) begin
        hold_left <= LONG_HOLD;
        hold_idx  <= hold_idx + 1;
      end
    end
  end

  // result monitor and short receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        check_result(out_item);
        sink_wait = draw_wait((seen_results / 50) % 3 == 2);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      out_ready <= (hold_left == 0 && sink_wait == 0);
    end
  end

  initial begin
    int unsigned pick, r, span, ops;
    int          k;
    logic [7:0]  cls, node;

    // directed: empty page, refusals, clamps, full page drain, unknown codes
    push_req(pbfl_pkg::REQ_ALLOC, 1, 0, 0);
    push_req(pbfl_pkg::REQ_CHECKED_FREE, 3, 0, 0);
    push_req(pbfl_pkg::REQ_UNCHECKED_FREE, 5, 0, 0);
    push_req(pbfl_pkg::REQ_ALLOC, 3, 0, 0);
    push_req(pbfl_pkg::REQ_CHECKED_FREE, 7, 0, 0);
    push_req(pbfl_pkg::REQ_UNCHECKED_FREE, 7, 0, 0);
    push_req(pbfl_pkg::REQ_MARK_UNUSED, 16'hFFFF, 0, 0);
    push_req(pbfl_pkg::REQ_ALLOC, 0, 0, 0);
    push_req(pbfl_pkg::REQ_INIT, 0, 8'hFF, 8'hFF);
    push_req(pbfl_pkg::REQ_ALLOC, 2, 0, 0);
    push_req(pbfl_pkg::REQ_INIT, pbfl_pkg::MAX_BLOCKS, 8'hFF, 8'hFF);
    push_req(pbfl_pkg::REQ_INIT, 511, 8'h00, 8'h00);
    push_req(pbfl_pkg::REQ_ALLOC, 127, 0, 0);
    push_req(pbfl_pkg::REQ_ALLOC, 0, 0, 0);
    push_req(pbfl_pkg::REQ_CHECKED_FREE, 255, 0, 0);
    push_req(pbfl_pkg::REQ_UNCHECKED_FREE, 0, 0, 0);
    repeat (4) push_req(pbfl_pkg::REQ_ALLOC, pbfl_pkg::MAX_REQUEST, 0, 0);
    for (k = int'(pbfl_pkg::REQ_UNCHECKED_FREE) + 1; k < 8; k++) push_req(3'(k), 9, 0, 0);
    push_req(pbfl_pkg::REQ_MARK_UNUSED, 16'h1234, 0, 0);
    push_req(pbfl_pkg::REQ_INIT, 2, 8'h00, 8'h00);

    // random: mostly init sessions with allocs and frees inside the page
    cls  = 8'($urandom);
    node = 8'($urandom);
    while (req_total < REQ_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        if (pick >= 12) begin
          cls  = 8'($urandom);
          node = 8'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r < 6) span = $urandom_range(1, 24);
        else if (r < 8) span = $urandom_range(25, 255);
        else if (r == 8) span = pbfl_pkg::MAX_BLOCKS;
        else span = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
        push_req(pbfl_pkg::REQ_INIT, span, cls, node);
        if (span == 0) span = 1;
        if (span > pbfl_pkg::MAX_BLOCKS) span = pbfl_pkg::MAX_BLOCKS;
        ops = $urandom_range(4, 16);
        repeat (ops) begin
          r = $urandom_range(0, 19);
          if (r < 8) begin
            push_req(pbfl_pkg::REQ_ALLOC, $urandom_range(1, 6), 0, 0);
          end else if (r < 9) begin
            push_req(pbfl_pkg::REQ_ALLOC, 0, 0, 0);
          end else if (r < 11) begin
            push_req(pbfl_pkg::REQ_ALLOC, $urandom_range(7, pbfl_pkg::MAX_REQUEST), 0, 0);
          end else if (r < 12) begin
            push_req(pbfl_pkg::REQ_ALLOC,
                     $urandom_range(pbfl_pkg::MAX_REQUEST + 1, 127), 0, 0);
          end else if (r < 16) begin
            push_req(pbfl_pkg::REQ_CHECKED_FREE, $urandom_range(0, span - 1), 0, 0);
          end else begin
            push_req(pbfl_pkg::REQ_UNCHECKED_FREE, $urandom_range(0, span - 1), 0, 0);
          end
        end
      end else if (pick < 88) begin
        push_item(noise_item());
      end else if (pick < 94) begin
        push_req(pbfl_pkg::REQ_MARK_UNUSED, $urandom_range(0, 65535), 0, 0);
      end else begin
        // broken sequence: allocs and frees on whatever the page holds
        repeat ($urandom_range(1, 4))
          push_req(3'($urandom_range(int'(pbfl_pkg::REQ_ALLOC),
                                     int'(pbfl_pkg::REQ_UNCHECKED_FREE))),
                   $urandom_range(0, 255), 0, 0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_reqs != queued_total) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0)
      $display("page_block_free_list_top_tb: done, clean");
    else
      $display("page_block_free_list_top_tb: done, errors");
    $finish;
  end

  // run limit, 20 ms
  initial begin
    #20_000_000;
    $display("page_block_free_list_top_tb: done, errors");
    $finish;
  end

endmodule
